>>> design/jkvl_pkg.sv
// Package for the JSON key/value locator: scan modes, result record.
// No dependencies.
package jkvl_pkg;

    // Scanner modes.
    typedef enum logic [3:0] {
        M_TOP        = 4'd0,
        M_KEY        = 4'd1,
        M_KEY_ESC    = 4'd2,
        M_AFTER_STR  = 4'd3,
        M_WAIT_MATCH = 4'd4,
        M_WAIT_SKIP  = 4'd5,
        M_SKIP_STR   = 4'd6,
        M_SKIP_ESC   = 4'd7,
        M_SKIP_CONT  = 4'd8,
        M_LITERAL    = 4'd9,
        M_NUMBER     = 4'd10
    } t_mode;

    // Configuration register indexes.
    localparam logic [2:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] CFG_KEY_WORD0  = 3'd1;
    localparam logic [2:0] CFG_KEY_WORD1  = 3'd2;
    localparam logic [2:0] CFG_KEY_WORD2  = 3'd3;
    localparam logic [2:0] CFG_KEY_WORD3  = 3'd4;

    localparam int KEY_WORDS = 4;

    // Literal kinds.
    localparam logic [1:0] LIT_TRUE  = 2'd1;
    localparam logic [1:0] LIT_FALSE = 2'd2;
    localparam logic [1:0] LIT_NULL  = 2'd3;

    // Result record: found flag, value offset and first value byte.
    typedef struct packed {
        logic        found;
        logic [31:0] offset;
        logic [7:0]  first_byte;
    } t_result;

    // Expected character of a literal at a given position.
    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (kind)
            LIT_FALSE: case (pos)
                3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s"; 3'd4: c = "e";
                default: c = 8'h00;
            endcase
            LIT_NULL: case (pos)
                3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
                default: c = 8'h00;
            endcase
            default: case (pos)
                3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
                default: c = 8'h00;
            endcase
        endcase
        return c;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        return (kind == LIT_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

endpackage

>>> design/jkvl_front.sv
// Front part: takes text bytes, keeps the byte offset and compares each byte
// against the configured key byte at the current index. Uses jkvl_pkg.
module jkvl_front #(
    parameter int KEY_MAX_BYTES = 32,
    parameter int OFFSET_BITS   = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [63:0]            i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    input  logic [5:0]             i_key_index,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_byte,
    output logic                   o_last,
    output logic [OFFSET_BITS-1:0] o_offset,
    output logic                   o_key_eq,
    output logic [5:0]             o_key_len
);
    import jkvl_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OMAX = {OFFSET_BITS{1'b1}};
    localparam logic [5:0] KMAX = 6'(KEY_MAX_BYTES);

    logic [5:0]             r_key_length;
    logic [63:0]            r_key_word [KEY_WORDS];
    logic [OFFSET_BITS-1:0] r_offset;
    logic                   r_valid;
    logic [7:0]             r_byte;
    logic                   r_last;
    logic [OFFSET_BITS-1:0] r_off_q;
    logic                   r_key_eq;
    logic [7:0]             n_key_byte;
    logic                   w_take;

    // Stage register advances when empty or drained.
    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    // Key byte lookup; the index comes from the back part and is stable
    // for the next byte because the back part commits before this compare is used.
    always_comb begin
        n_key_byte = 8'h00;
        if (i_key_index < 6'd32)
            n_key_byte = r_key_word[i_key_index[4:3]][8*i_key_index[2:0] +: 8];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= '0;
            for (int i = 0; i < KEY_WORDS; i++) r_key_word[i] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_LENGTH: r_key_length <= i_cfg_data[5:0];
                CFG_KEY_WORD0:  r_key_word[0] <= i_cfg_data;
                CFG_KEY_WORD1:  r_key_word[1] <= i_cfg_data;
                CFG_KEY_WORD2:  r_key_word[2] <= i_cfg_data;
                CFG_KEY_WORD3:  r_key_word[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Offset counter and stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (o_ready) r_valid <= i_valid;
            if (w_take) begin
                if (i_last) r_offset <= '0;
                else if (r_offset != OMAX) r_offset <= r_offset + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte  <= i_byte;
            r_last  <= i_last;
            r_off_q <= r_offset;
        end
    end

    // Key compare is done against the live index in the back part's cycle.
    always_ff @(posedge i_clk) begin
        r_key_eq <= 1'b0;
        if (w_take) r_key_eq <= 1'b0;
    end

    assign o_valid   = r_valid;
    assign o_byte    = r_byte;
    assign o_last    = r_last;
    assign o_offset  = r_off_q;
    assign o_key_eq  = (r_byte == n_key_byte) | r_key_eq;
    assign o_key_len = (r_key_length > KMAX) ? KMAX : r_key_length;
endmodule

>>> design/jkvl_back.sv
// Back part: the scanner state machine, one byte per cycle while no result
// waits unaccepted, and the one-entry result register to the output. Uses jkvl_pkg.
module jkvl_back #(
    parameter int OFFSET_BITS = 20,
    parameter int DEPTH_BITS  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_byte,
    input  logic                   i_last,
    input  logic [OFFSET_BITS-1:0] i_offset,
    input  logic                   i_key_eq,
    input  logic [5:0]             i_key_len,
    output logic [5:0]             o_key_index,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_found,
    output logic [OFFSET_BITS-1:0] o_offset,
    output logic [7:0]             o_first
);
    import jkvl_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OMAX = {OFFSET_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0]  DMAX = {DEPTH_BITS{1'b1}};

    t_mode                 r_mode, n_mode;
    logic [DEPTH_BITS-1:0] r_depth, n_depth;
    logic                  r_obj, n_obj;
    logic                  r_sinv, n_sinv;
    logic [5:0]            r_kidx, n_kidx;
    logic                  r_kmatch, n_kmatch;
    logic [1:0]            r_lkind, n_lkind;
    logic [2:0]            r_lprog, n_lprog;
    logic [1:0]            r_nph, n_nph;
    logic                  r_given;
    logic                  r_ovalid;
    logic                  r_ofound;
    logic [OFFSET_BITS-1:0] r_ooff;
    logic [7:0]            r_ofirst;
    logic [1:0]            w_res;     // 0 none, 1 not found, 2 found
    logic                  w_emit, w_found;
    logic [OFFSET_BITS-1:0] w_off;
    logic [7:0]            w_first;
    logic                  w_take;
    logic [7:0]            b;

    assign b       = i_byte;
    // Output register holds one result; while it waits unaccepted, no byte is taken.
    assign o_ready = !r_ovalid || i_ready;
    assign w_take  = i_valid && o_ready;
    assign o_key_index = r_kidx;

    // Scanner next-state logic.
    always_comb begin
        logic err;
        logic [7:0] lc;
        logic [2:0] ll;
        logic top;      // fall back to top-level handling of b
        logic startv;   // start a value to skip
        n_mode = r_mode; n_depth = r_depth; n_obj = r_obj; n_sinv = r_sinv;
        n_kidx = r_kidx; n_kmatch = r_kmatch; n_lkind = r_lkind;
        n_lprog = r_lprog; n_nph = r_nph;
        w_res = 2'd0; err = 1'b0; top = 1'b0; startv = 1'b0;
        lc = lit_char(r_lkind, r_lprog);
        ll = lit_len(r_lkind);
        if (b == 8'h00) begin
            w_res = (r_mode == M_WAIT_MATCH) ? 2'd2 : 2'd1;
        end else begin
            unique case (r_mode)
                M_KEY: begin
                    if (b == "\"") begin
                        n_kmatch = r_kmatch && (r_kidx == i_key_len);
                        n_mode = M_AFTER_STR;
                    end else begin
                        if (b == "\\") n_mode = M_KEY_ESC;
                        if (!r_kmatch || r_kidx >= i_key_len || !i_key_eq) n_kmatch = 1'b0;
                        if (r_kidx != 6'd63) n_kidx = r_kidx + 1'b1;
                    end
                end
                M_KEY_ESC: begin
                    if (!r_kmatch || r_kidx >= i_key_len || !i_key_eq) n_kmatch = 1'b0;
                    if (r_kidx != 6'd63) n_kidx = r_kidx + 1'b1;
                    n_mode = M_KEY;
                end
                M_AFTER_STR: begin
                    if (b == ":") n_mode = r_kmatch ? M_WAIT_MATCH : M_WAIT_SKIP;
                    else if (!is_ws(b)) top = 1'b1;
                end
                M_WAIT_MATCH: if (!is_ws(b)) w_res = 2'd2;
                M_WAIT_SKIP:  if (!is_ws(b)) startv = 1'b1;
                M_SKIP_STR: begin
                    if (b == "\"") n_mode = r_sinv ? M_SKIP_CONT : M_TOP;
                    else if (b == "\\") n_mode = M_SKIP_ESC;
                end
                M_SKIP_ESC: n_mode = M_SKIP_STR;
                M_SKIP_CONT: begin
                    if (b == "\"") begin
                        n_mode = M_SKIP_STR; n_sinv = 1'b1;
                    end else if (b == (r_obj ? 8'h7B : 8'h5B)) begin
                        if (r_depth == DMAX) err = 1'b1;
                        else n_depth = r_depth + 1'b1;
                    end else if (b == (r_obj ? 8'h7D : 8'h5D)) begin
                        if (r_depth <= DEPTH_BITS'(1)) begin
                            n_depth = '0; n_mode = M_TOP;
                        end else n_depth = r_depth - 1'b1;
                    end
                end
                M_LITERAL: begin
                    if (r_lprog >= ll || b != lc) err = 1'b1;
                    else if (r_lprog + 3'd1 >= ll) begin
                        n_lprog = '0; n_lkind = '0; n_mode = M_TOP;
                    end else n_lprog = r_lprog + 3'd1;
                end
                M_NUMBER: begin
                    case (r_nph)
                        2'd0: begin
                            if (b == ".") n_nph = 2'd1;
                            else if (b == "e" || b == "E") n_nph = 2'd2;
                            else if (!is_digit(b)) top = 1'b1;
                        end
                        2'd1: begin
                            if (b == "e" || b == "E") n_nph = 2'd2;
                            else if (!is_digit(b)) top = 1'b1;
                        end
                        2'd2: begin
                            if (b == "+" || b == "-" || is_digit(b)) n_nph = 2'd3;
                            else top = 1'b1;
                        end
                        default: if (!is_digit(b)) top = 1'b1;
                    endcase
                    if (top) n_nph = 2'd0;
                end
                default: top = 1'b1;
            endcase
            // Top-level handling shared by several modes.
            if (top) begin
                n_mode = M_TOP;
                if (b == "\"") begin
                    n_mode = M_KEY; n_kidx = '0; n_kmatch = 1'b1;
                end else if (!(is_ws(b) || b == "{" || b == "[" || b == "," || b == ":"
                               || b == "}" || b == "]")) startv = 1'b1;
            end
            // Start of a value that is skipped.
            if (startv) begin
                if (b == "\"") begin
                    n_mode = M_SKIP_STR; n_sinv = 1'b0;
                end else if (b == "{" || b == "[") begin
                    n_mode = M_SKIP_CONT; n_obj = (b == "{"); n_depth = DEPTH_BITS'(1);
                end else if (b == "t" || b == "f" || b == "n") begin
                    n_mode = M_LITERAL;
                    n_lkind = (b == "t") ? LIT_TRUE : (b == "f") ? LIT_FALSE : LIT_NULL;
                    n_lprog = 3'd1;
                end else if (b == "-" || is_digit(b)) begin
                    n_mode = M_NUMBER; n_nph = 2'd0;
                end else err = 1'b1;
            end
            if (err) w_res = 2'd1;
        end
    end

    // Result selection.
    always_comb begin
        w_emit = 1'b0; w_found = 1'b0; w_off = '0; w_first = 8'h00;
        if (!r_given) begin
            if (w_res == 2'd2) begin
                w_emit = 1'b1; w_found = 1'b1; w_off = i_offset; w_first = b;
            end else if (w_res == 2'd1) begin
                w_emit = 1'b1;
            end else if (i_last) begin
                w_emit = 1'b1;
                if (n_mode == M_WAIT_MATCH) begin
                    w_found = 1'b1;
                    w_off = (i_offset == OMAX) ? OMAX : i_offset + 1'b1;
                end
            end
        end
    end

    // Scanner state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_take && i_last)) begin
            r_mode <= M_TOP; r_depth <= '0; r_obj <= 1'b0; r_sinv <= 1'b0;
            r_kidx <= '0; r_kmatch <= 1'b1; r_lkind <= '0; r_lprog <= '0;
            r_nph <= '0; r_given <= 1'b0;
        end else if (w_take) begin
            r_mode <= n_mode; r_depth <= n_depth; r_obj <= n_obj; r_sinv <= n_sinv;
            r_kidx <= n_kidx; r_kmatch <= n_kmatch; r_lkind <= n_lkind;
            r_lprog <= n_lprog; r_nph <= n_nph;
            if (w_emit) r_given <= 1'b1;
        end
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_take && w_emit) r_ovalid <= 1'b1;
        else if (i_ready) r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_emit) begin
            r_ofound <= w_found; r_ooff <= w_off; r_ofirst <= w_first;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_found  = r_ofound;
    assign o_offset = r_ooff;
    assign o_first  = r_ofirst;
endmodule

>>> design/json_key_value_locator.sv
// Top level of the JSON key/value locator.
// Instantiates jkvl_front and jkvl_back; uses jkvl_pkg.
//
// Channel   Direction  Payload
// s_axis    in         tdata = text_byte, tuser = last_byte
// m_axis    out        tdata = found, value_offset, value_first_byte
// cfg       in         we / index / data, key_length and key_word0..3
//
// One byte per cycle while m_axis_tready does not hold a result back. After the
// byte that gives a result is accepted, the front stage registers the byte and its
// offset, then the scanner updates state and fills the one-entry result register.
// Synchronous active-low reset; no clearing pass. While a result waits with
// m_axis_tready low, the scanner holds and s_axis_tready falls once the front
// stage holds a byte.
module json_key_value_locator #(
    parameter int KEY_MAX_BYTES = 32,
    parameter int OFFSET_BITS   = 20,
    parameter int DEPTH_BITS    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [63:0]           i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // text_byte
    input  logic                  s_axis_tuser,   // last_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [((1+OFFSET_BITS+8+7)/8)*8-1:0] m_axis_tdata // found, offset, first byte
);
    import jkvl_pkg::*;

    localparam int TW = ((1 + OFFSET_BITS + 8 + 7) / 8) * 8;

    logic                   w_valid, w_ready, w_last, w_key_eq, w_found;
    logic [7:0]             w_byte, w_first;
    logic [OFFSET_BITS-1:0] w_off, w_ooff;
    logic [5:0]             w_key_len, w_key_index;

    jkvl_front #(.KEY_MAX_BYTES(KEY_MAX_BYTES), .OFFSET_BITS(OFFSET_BITS)) u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata), .i_last(s_axis_tuser), .i_key_index(w_key_index),
        .o_valid(w_valid), .i_ready(w_ready), .o_byte(w_byte), .o_last(w_last),
        .o_offset(w_off), .o_key_eq(w_key_eq), .o_key_len(w_key_len)
    );

    jkvl_back #(.OFFSET_BITS(OFFSET_BITS), .DEPTH_BITS(DEPTH_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_valid), .o_ready(w_ready),
        .i_byte(w_byte), .i_last(w_last), .i_offset(w_off), .i_key_eq(w_key_eq),
        .i_key_len(w_key_len), .o_key_index(w_key_index),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_found(w_found), .o_offset(w_ooff), .o_first(w_first)
    );

    // Pack the result fields, lowest first.
    assign m_axis_tdata = TW'({w_first, w_ooff, w_found});
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for json_key_value_locator: streams JSON documents and
// compares every result transaction against a behavioral predictor of the scanner.
// Depends on the RTL in design/ and on jkvl_pkg.
module tb_top;
    import jkvl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFFSET_MAX  = (1 << 20) - 1;
    localparam int DEPTH_MAX   = (1 << 16) - 1;
    localparam int KEY_BYTES   = 32;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_WAIT  = 6;
    localparam byte QUOTE      = 8'h22;
    localparam byte BACKSLASH  = 8'h5C;

    // One result transaction as the scanner reports it.
    typedef struct packed {
        bit        found;
        bit [19:0] offset;
        bit [7:0]  first_byte;
    } t_locate;

    // Predicts the locator's results from the accepted bytes and checks them.
    class locate_scoreboard;
        bit [5:0]    key_len;
        bit [63:0]   key_word[4];
        t_mode       mode;
        int unsigned depth;
        bit          skip_obj;
        bit          str_in_skip;
        int unsigned key_idx;
        bit          key_ok;
        int unsigned lit_kind;
        int unsigned lit_pos;
        int unsigned num_phase;
        int unsigned offset;
        bit          given;
        t_locate     pending[$];
        int          errors;
        int          checked;
        int          hits;
        string       lit_text[3] = '{"true", "false", "null"};

        function void clear_doc();
            mode = M_TOP;
            depth = 0;
            skip_obj = 0;
            str_in_skip = 0;
            key_idx = 0;
            key_ok = 1;
            lit_kind = 0;
            lit_pos = 0;
            num_phase = 0;
            offset = 0;
            given = 0;
        endfunction

        function void write_reg(bit [2:0] idx, bit [63:0] val);
            case (idx)
                CFG_KEY_LENGTH: key_len = val[5:0];
                CFG_KEY_WORD0:  key_word[0] = val;
                CFG_KEY_WORD1:  key_word[1] = val;
                CFG_KEY_WORD2:  key_word[2] = val;
                CFG_KEY_WORD3:  key_word[3] = val;
                default: ;
            endcase
        endfunction

        function int unsigned eff_len();
            return (key_len > KEY_BYTES) ? KEY_BYTES : key_len;
        endfunction

        function bit is_space(byte unsigned b);
            return b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D;
        endfunction

        function bit is_num(byte unsigned b);
            return b >= 8'h30 && b <= 8'h39;
        endfunction

        // Raw key comparison, one byte at a time.
        function void key_feed(byte unsigned b);
            byte unsigned kb;
            kb = (key_idx >= KEY_BYTES) ? 8'h00 : key_word[key_idx >> 3][(key_idx & 7) * 8 +: 8];
            if (!key_ok || key_idx >= eff_len() || b != kb) key_ok = 0;
            if (key_idx < 63) key_idx++;
        endfunction

        // Opens a value that is to be skipped; returns 1 on a malformed start.
        function bit open_value(byte unsigned b);
            if (b == QUOTE) begin
                mode = M_SKIP_STR;
                str_in_skip = 0;
            end else if (b == "{" || b == "[") begin
                mode = M_SKIP_CONT;
                skip_obj = (b == "{");
                depth = 1;
            end else if (b == "t" || b == "f" || b == "n") begin
                mode = M_LITERAL;
                lit_kind = (b == "t") ? 1 : (b == "f") ? 2 : 3;
                lit_pos = 1;
            end else if (b == "-" || is_num(b)) begin
                mode = M_NUMBER;
                num_phase = 0;
            end else begin
                return 1;
            end
            return 0;
        endfunction

        function bit scan_byte(byte unsigned b);
            mode = M_TOP;
            if (is_space(b)) return 0;
            if (b == QUOTE) begin
                mode = M_KEY;
                key_idx = 0;
                key_ok = 1;
                return 0;
            end
            if (b == "{" || b == "[" || b == "," || b == ":" || b == "}" || b == "]") return 0;
            return open_value(b);
        endfunction

        function bit number_byte(byte unsigned b);
            case (num_phase)
                0: begin
                    if (is_num(b)) return 0;
                    if (b == ".") begin num_phase = 1; return 0; end
                    if (b == "e" || b == "E") begin num_phase = 2; return 0; end
                end
                1: begin
                    if (is_num(b)) return 0;
                    if (b == "e" || b == "E") begin num_phase = 2; return 0; end
                end
                2: begin
                    if (b == "+" || b == "-" || is_num(b)) begin num_phase = 3; return 0; end
                end
                default: begin
                    if (is_num(b)) return 0;
                end
            endcase
            num_phase = 0;
            return scan_byte(b);
        endfunction

        // Advances the scanner: 0 nothing yet, 1 not found, 2 found here.
        function int advance(byte unsigned b);
            string s;
            if (b == 0) return (mode == M_WAIT_MATCH) ? 2 : 1;
            case (mode)
                M_KEY: begin
                    if (b == QUOTE) begin
                        key_ok = key_ok && (key_idx == eff_len());
                        mode = M_AFTER_STR;
                        return 0;
                    end
                    if (b == BACKSLASH) mode = M_KEY_ESC;
                    key_feed(b);
                    return 0;
                end
                M_KEY_ESC: begin
                    key_feed(b);
                    mode = M_KEY;
                    return 0;
                end
                M_AFTER_STR: begin
                    if (is_space(b)) return 0;
                    if (b == ":") begin
                        mode = key_ok ? M_WAIT_MATCH : M_WAIT_SKIP;
                        return 0;
                    end
                    return scan_byte(b);
                end
                M_WAIT_MATCH: return is_space(b) ? 0 : 2;
                M_WAIT_SKIP:  return is_space(b) ? 0 : open_value(b);
                M_SKIP_STR: begin
                    if (b == QUOTE) mode = str_in_skip ? M_SKIP_CONT : M_TOP;
                    else if (b == BACKSLASH) mode = M_SKIP_ESC;
                    return 0;
                end
                M_SKIP_ESC: begin
                    mode = M_SKIP_STR;
                    return 0;
                end
                M_SKIP_CONT: begin
                    if (b == QUOTE) begin
                        mode = M_SKIP_STR;
                        str_in_skip = 1;
                    end else if (b == (skip_obj ? "{" : "[")) begin
                        if (depth >= DEPTH_MAX) return 1;
                        depth++;
                    end else if (b == (skip_obj ? "}" : "]")) begin
                        if (depth <= 1) begin
                            depth = 0;
                            mode = M_TOP;
                        end else begin
                            depth--;
                        end
                    end
                    return 0;
                end
                M_LITERAL: begin
                    s = lit_text[(lit_kind >= 1 && lit_kind <= 3) ? lit_kind - 1 : 0];
                    if (lit_pos >= s.len() || b != s[lit_pos]) return 1;
                    lit_pos++;
                    if (lit_pos >= s.len()) begin
                        lit_pos = 0;
                        lit_kind = 0;
                        mode = M_TOP;
                    end
                    return 0;
                end
                M_NUMBER: return number_byte(b);
                default: return scan_byte(b);
            endcase
        endfunction

        function void post(bit f, int unsigned off, byte unsigned fb);
            t_locate r;
            r.found = f;
            r.offset = off[19:0];
            r.first_byte = fb;
            pending.push_back(r);
            given = 1;
        endfunction

        // Called for every accepted input transaction.
        function void note_byte(byte unsigned b, bit last);
            int unsigned nxt;
            int r;
            nxt = (offset < OFFSET_MAX) ? offset + 1 : OFFSET_MAX;
            if (!given) begin
                r = advance(b);
                if (r == 2) post(1, offset, b);
                else if (r == 1) post(0, 0, 0);
                else if (last) begin
                    if (mode == M_WAIT_MATCH) post(1, nxt, 0);
                    else post(0, 0, 0);
                end
            end
            if (last) clear_doc();
            else offset = nxt;
        endfunction

        // Called for every accepted result transaction.
        function void check_result(bit [31:0] data);
            t_locate got, exp_r;
            got.found = data[0];
            got.offset = data[20:1];
            got.first_byte = data[28:21];
            if (got.found) hits++;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result found=%0d offset=%0d byte=%02h",
                             got.found, got.offset, got.first_byte);
                return;
            end
            exp_r = pending.pop_front();
            if (got != exp_r) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: expected found=%0d offset=%0d byte=%02h, got %0d %0d %02h",
                             exp_r.found, exp_r.offset, exp_r.first_byte,
                             got.found, got.offset, got.first_byte);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // text_byte
    logic        s_axis_tuser;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // found, value_offset, value_first_byte

    locate_scoreboard sb = new();
    byte unsigned doc[$];
    string       cur_key;
    bit          sender_idle;
    bit          receiver_idle;
    int          stall_left;
    int          cycles;
    int          bytes_sent;
    int          docs_sent;

    json_key_value_locator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: check each transaction, then draw the next stall.
    initial begin
        m_axis_tready = 1'b0;
        stall_left = 0;
    end
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
            stall_left = receiver_idle ? $urandom_range(0, 14) : 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end
        m_axis_tready <= i_rst_n && (stall_left == 0);
        if ($urandom_range(0, 199) == 0) receiver_idle = ~receiver_idle;
    end

    // Sends one byte, with a random gap before it when idling is on.
    task automatic send_byte(byte unsigned b, bit last);
        int gap;
        gap = sender_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tuser <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_doc();
        sender_idle = ($urandom_range(0, 9) < 7);
        foreach (doc[i]) send_byte(doc[i], i == doc.size() - 1);
        docs_sent++;
        doc.delete();
    endtask

    // Holds the sender until every expected result has arrived.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_cfg(bit [2:0] idx, bit [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // Loads a key: its bytes go into the four words, then the length.
    task automatic load_key(string k, bit [5:0] len);
        bit [63:0] w[4];
        for (int i = 0; i < 4; i++) w[i] = '0;
        foreach (k[i]) if (i < KEY_BYTES) w[i >> 3][(i & 7) * 8 +: 8] = k[i];
        drain();
        write_cfg(CFG_KEY_WORD0, w[0]);
        write_cfg(CFG_KEY_WORD1, w[1]);
        write_cfg(CFG_KEY_WORD2, w[2]);
        write_cfg(CFG_KEY_WORD3, w[3]);
        write_cfg(CFG_KEY_LENGTH, 64'(len));
        cur_key = k;
    endtask

    task automatic add_text(string s);
        foreach (s[i]) doc.push_back(s[i]);
    endtask

    task automatic add_space();
        string sp;
        sp = " \t\n\r";
        repeat ($urandom_range(0, 2)) doc.push_back(sp[$urandom_range(0, 3)]);
    endtask

    task automatic gen_string(bit as_key);
        string pool, esc;
        byte unsigned c;
        pool = "abiXYZ_09 :{\\";
        esc = "\"\\n/u";
        doc.push_back(QUOTE);
        if (as_key && $urandom_range(0, 1)) begin
            add_text(cur_key);
        end else begin
            repeat ($urandom_range(0, 6)) begin
                c = pool[$urandom_range(0, pool.len() - 1)];
                doc.push_back(c);
                if (c == BACKSLASH) doc.push_back(esc[$urandom_range(0, esc.len() - 1)]);
            end
        end
        doc.push_back(QUOTE);
    endtask

    task automatic gen_digits();
        repeat ($urandom_range(1, 3)) doc.push_back(8'(8'h30 + $urandom_range(0, 9)));
    endtask

    task automatic gen_number();
        string ex;
        ex = "eE";
        if ($urandom_range(0, 2) == 0) doc.push_back("-");
        gen_digits();
        if ($urandom_range(0, 1)) begin doc.push_back("."); gen_digits(); end
        if ($urandom_range(0, 2) == 0) begin
            doc.push_back(ex[$urandom_range(0, 1)]);
            if ($urandom_range(0, 1)) doc.push_back($urandom_range(0, 1) ? "+" : "-");
            gen_digits();
        end
    endtask

    task automatic gen_value(int lvl);
        int n;
        case ($urandom_range(0, 9))
            0, 1: if (lvl < 3) begin
                doc.push_back("{");
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++) begin
                    if (i) doc.push_back(",");
                    add_space(); gen_string(1); add_space();
                    doc.push_back(":"); add_space();
                    gen_value(lvl + 1); add_space();
                end
                doc.push_back("}");
            end else gen_number();
            2: if (lvl < 3) begin
                doc.push_back("[");
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    if (i) doc.push_back(",");
                    add_space(); gen_value(lvl + 1);
                end
                doc.push_back("]");
            end else gen_number();
            3, 4: gen_string(0);
            5, 6: gen_number();
            7: add_text("true");
            8: add_text("false");
            default: add_text("null");
        endcase
    endtask

    // One random document: mostly well-formed, sometimes corrupted, truncated or noise.
    task automatic random_doc();
        int kind, n;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 20))
                doc.push_back(8'($urandom_range(0, 7) ? $urandom_range(1, 255) : 0));
        end else begin
            doc.push_back("{");
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                if (i) doc.push_back(",");
                add_space(); gen_string(1); add_space();
                doc.push_back(":"); add_space(); gen_value(1);
            end
            doc.push_back("}");
            if (kind == 1) doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
            if (kind == 2) doc = doc[0:$urandom_range(0, doc.size() - 1)];
        end
        send_doc();
    endtask

    task automatic random_phase(int items);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < items) random_doc();
    endtask

    task automatic directed(string s);
        add_text(s);
        send_doc();
    endtask

    // Stimulus.
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_KEY_LENGTH;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
        bytes_sent = 0;
        docs_sent = 0;
        cur_key = "";
        sb.key_len = 0;
        for (int i = 0; i < 4; i++) sb.key_word[i] = '0;
        sb.clear_doc();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: the empty key.
        directed("{\"\":5}");
        random_phase(200);

        // Short key with the special cases.
        load_key("id", 2);
        directed("{\"id\": 42}");
        directed("{\"x\":{\"id\":1},\"id\" :\"v\"}");
        directed("{\"a\":[1,[2]],\"b\":true,\"c\":false,\"d\":null,\"e\":-1.5e+3,\"id\":\t7}");
        directed("{\"i\\d\":1,\"s\":\"a\\\"b\"}");
        directed("{\"id\":");
        directed("{\"id\":1,\"id\":2}");
        directed("{\"a\":tru}");
        directed("{\"a\":@}");
        add_text("{\"id\":"); doc.push_back(0); directed("");
        add_text("{\"id\""); doc.push_back(0); directed("");
        random_phase(250);

        // Full-size key, then a length above the clamp.
        load_key("abcdefghijklmnopqrstuvwxyz012345", 32);
        random_phase(200);
        load_key("abcdefghijklmnopqrstuvwxyz012345", 63);
        random_phase(100);

        // All-ones key bytes.
        load_key(string'({8{8'hFF}}), 8);
        directed({"{\"", string'({8{8'hFF}}), "\":1}"});
        drain();
        for (int i = 0; i < 4; i++) write_cfg(3'(CFG_KEY_WORD0 + i), '1);
        random_phase(100);

        // Random printable key of random length.
        begin
            string k;
            k = "";
            repeat ($urandom_range(1, 12)) k = {k, string'(byte'($urandom_range(97, 122)))};
            load_key(k, 6'(k.len()));
        end
        random_phase(250);

        drain();
        $display("Sent %0d documents (%0d bytes) over six key settings.", docs_sent, bytes_sent);
        $display("Checked %0d results, %0d of them with the key found.", sb.checked, sb.hits);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
